>>> hdl/sdsh_pkg.sv
// Types, codes and helpers shared by the SD card SPI host sequencer.
package sdsh_pkg;

   localparam int unsigned BLOCK_BYTES = 512;

   typedef enum logic [5:0] {
      PH_IDLE, I_WAKE, I_CMD0, I_CMD8, I_R7, I_V2_55, I_V2_41, I_CMD58, I_OCR,
      I_V1_55, I_V1_41, I_V1L_55, I_V1L_41, I_MMC, I_CMD16,
      R_CMD, R_TOKEN, R_DATA, R_CRC, R_STOP,
      W_55, W_23, W_CMD, W_READY, W_DATA, W_CRC, W_RESP, W_STOPRDY, W_STOPTOK,
      PH_FIN
   } phase_type;

   typedef enum logic [2:0] {
      E_NONE, E_DESEL, E_READY, E_SELFAIL, E_FRAME, E_RESP
   } eng_type;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_RESP   = 3'd1;
   localparam logic [2:0] ST_CMD_ERR   = 3'd2;
   localparam logic [2:0] ST_TOKEN_TO  = 3'd3;
   localparam logic [2:0] ST_WR_REJECT = 3'd4;
   localparam logic [2:0] ST_BUSY_TO   = 3'd5;
   localparam logic [2:0] ST_INIT_FAIL = 3'd6;

   localparam logic [2:0] CT_NONE = 3'd0;
   localparam logic [2:0] CT_MMC  = 3'd1;
   localparam logic [2:0] CT_SD1  = 3'd2;
   localparam logic [2:0] CT_SD2  = 3'd3;
   localparam logic [2:0] CT_SDHC = 3'd4;

   localparam logic [2:0] REG_RESET_RETRY = 3'd0;
   localparam logic [2:0] REG_INIT_RETRY  = 3'd1;
   localparam logic [2:0] REG_RESP_POLL   = 3'd2;
   localparam logic [2:0] REG_READY_WAIT  = 3'd3;
   localparam logic [2:0] REG_TOKEN_WAIT  = 3'd4;
   localparam logic [2:0] REG_WAKEUP      = 3'd5;

   localparam logic [5:0] CMD0  = 6'd0;
   localparam logic [5:0] CMD1  = 6'd1;
   localparam logic [5:0] CMD8  = 6'd8;
   localparam logic [5:0] CMD12 = 6'd12;
   localparam logic [5:0] CMD16 = 6'd16;
   localparam logic [5:0] CMD17 = 6'd17;
   localparam logic [5:0] CMD18 = 6'd18;
   localparam logic [5:0] CMD23 = 6'd23;
   localparam logic [5:0] CMD24 = 6'd24;
   localparam logic [5:0] CMD25 = 6'd25;
   localparam logic [5:0] CMD41 = 6'd41;
   localparam logic [5:0] CMD55 = 6'd55;
   localparam logic [5:0] CMD58 = 6'd58;

   localparam logic [7:0] FILL_BYTE   = 8'hFF;
   localparam logic [7:0] TOK_START   = 8'hFE;
   localparam logic [7:0] TOK_MULTI   = 8'hFC;
   localparam logic [7:0] TOK_STOP    = 8'hFD;
   localparam logic [7:0] DRESP_OK    = 8'h05;
   localparam logic [7:0] CRC_CMD0    = 8'h95;
   localparam logic [7:0] CRC_CMD8    = 8'h87;
   localparam logic [7:0] CRC_DUMMY   = 8'h01;
   localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS    = 32'h4000_0000;

   typedef struct packed {
      logic        func;
      logic [1:0]  op;
      logic [31:0] sector;
      logic [7:0]  count;
      logic [7:0]  miso_byte;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic       mosi_valid;
      logic [7:0] mosi_byte;
      logic       cs_active;
      logic       fast_clock;
      logic       read_valid;
      logic [7:0] read_data;
      logic       write_request;
      logic       done_res;
      logic [2:0] status;
      logic [7:0] response_code;
      logic [2:0] card_type;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  code;
      logic [31:0] arg;
      logic [7:0]  crc;
      phase_type   next;
   } cmd_type;

   function automatic cmd_type mk_cmd(logic [5:0] code, logic [31:0] arg,
                                      logic [7:0] crc, phase_type next);
      cmd_type c;
      c.code = code;
      c.arg  = arg;
      c.crc  = crc;
      c.next = next;
      return c;
   endfunction

   function automatic logic [7:0] frame_byte(logic [5:0] code, logic [31:0] arg,
                                             logic [7:0] crc, logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = {2'b01, code};
         3'd1:    b = arg[31:24];
         3'd2:    b = arg[23:16];
         3'd3:    b = arg[15:8];
         3'd4:    b = arg[7:0];
         3'd5:    b = crc;
         default: b = FILL_BYTE;
      endcase
      return b;
   endfunction

endpackage

>>> hdl/sd_card_spi_host_sequencer_unit.sv
// SD card SPI host sequencer: request and card-byte handling, one transaction per step.
// Each transaction is captured in the input register and its result in the result register.
// Throughput: one transaction per cycle while rsp_ready accepts results; the state update and the
// input and result registers all advance together and all stall while a result is not taken.
// Reset: synchronous, active high; clears the sequencer state and restores default limits.
module sd_card_spi_host_sequencer_unit
   import sdsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0]  reset_lim_ff, resp_lim_ff, wake_ff;
   logic [15:0] init_lim_ff, tok_lim_ff;
   logic [23:0] ready_lim_ff;

   logic    in_v_ff, out_v_ff, advance;
   req_type in_ff;
   rsp_type out_ff, out_in;

   phase_type   phase_ff, phase_in;
   eng_type     eng_ff, eng_in;
   logic [9:0]  bi_ff, bi_in, bi_n;
   logic [23:0] rc_ff, rc_in;
   logic [2:0]  dt_ff, dt_in;
   logic [31:0] ba_ff, ba_in, ba_n;
   logic [7:0]  bl_ff, bl_in, bl_n;
   logic [7:0]  lr_ff, lr_in;
   logic [7:0]  rb_ff [4];
   logic [7:0]  rb_in [4];
   logic [1:0]  op_ff, op_in;
   logic [15:0] tries_ff, tries_in;
   logic [5:0]  code_ff, code_in;
   logic [31:0] arg_ff, arg_in;
   logic [7:0]  crc_ff, crc_in;
   logic [2:0]  err_ff, err_in, e_cr;
   logic        multi_ff, multi_in, cs_ff, cs_in, fast_ff, fast_in;

   logic        do_start, do_fin, do_cres, cr_sf;
   logic [7:0]  cr_r, m;
   cmd_type     sc;

   assign pready    = 1'b1;
   assign advance   = in_v_ff && (!out_v_ff || rsp_ready);
   assign req_ready = !in_v_ff || advance;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign m         = in_ff.miso_byte;

   always_comb begin
      case (paddr[4:2])
         REG_RESET_RETRY: prdata = {24'd0, reset_lim_ff};
         REG_INIT_RETRY:  prdata = {16'd0, init_lim_ff};
         REG_RESP_POLL:   prdata = {24'd0, resp_lim_ff};
         REG_READY_WAIT:  prdata = {8'd0, ready_lim_ff};
         REG_TOKEN_WAIT:  prdata = {16'd0, tok_lim_ff};
         REG_WAKEUP:      prdata = {24'd0, wake_ff};
         default:         prdata = 32'd0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff; eng_in = eng_ff; bi_in = bi_ff; rc_in = rc_ff;
      dt_in = dt_ff; ba_in = ba_ff; bl_in = bl_ff; lr_in = lr_ff;
      rb_in = rb_ff; op_in = op_ff; tries_in = tries_ff; code_in = code_ff;
      arg_in = arg_ff; crc_in = crc_ff; err_in = err_ff; multi_in = multi_ff;
      cs_in = cs_ff; fast_in = fast_ff;
      out_in = '0;
      do_start = 1'b0; do_fin = 1'b0; do_cres = 1'b0; cr_sf = 1'b0; cr_r = 8'd0;
      sc = mk_cmd(CMD0, 32'd0, 8'd0, PH_IDLE);
      bi_n = 10'(bi_ff + 10'd1);
      bl_n = 8'(bl_ff - 8'd1);
      ba_n = (dt_ff == CT_SDHC) ? in_ff.sector : {in_ff.sector[22:0], 9'd0};
      e_cr = ST_OK;

      if (!in_ff.func) begin
         if (phase_ff == PH_IDLE) begin
            op_in = in_ff.op; err_in = ST_OK; eng_in = E_NONE;
            if (in_ff.op == OP_INIT) begin
               dt_in = CT_NONE; fast_in = 1'b0; bi_in = 10'd0; phase_in = I_WAKE;
               if (wake_ff != 8'd0) begin
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b0;
               end else begin
                  tries_in = 16'd0;
                  do_start = 1'b1; sc = mk_cmd(CMD0, 32'd0, CRC_CMD0, I_CMD0);
               end
            end else if (in_ff.op != OP_READ && in_ff.op != OP_WRITE) begin
               out_in.done_res = 1'b1; out_in.status = ST_CMD_ERR;
            end else if (in_ff.count == 8'd0) begin
               out_in.done_res = 1'b1; out_in.status = ST_OK;
            end else begin
               ba_in = ba_n; bl_in = in_ff.count; multi_in = (in_ff.count != 8'd1);
               do_start = 1'b1;
               if (in_ff.op == OP_READ)
                  sc = mk_cmd(multi_in ? CMD18 : CMD17, ba_n, CRC_DUMMY, R_CMD);
               else if (!multi_in)
                  sc = mk_cmd(CMD24, ba_n, CRC_DUMMY, W_CMD);
               else if (dt_ff != CT_MMC)
                  sc = mk_cmd(CMD55, 32'd0, CRC_DUMMY, W_55);
               else
                  sc = mk_cmd(CMD25, ba_n, CRC_DUMMY, W_CMD);
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         if (eng_ff != E_NONE) begin
            case (eng_ff)
               E_DESEL: begin
                  rc_in = 24'd0; eng_in = E_READY;
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
               end
               E_READY: begin
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  if (m == FILL_BYTE) begin
                     bi_in = 10'd1; eng_in = E_FRAME;
                     out_in.mosi_byte = frame_byte(code_ff, arg_ff, crc_ff, 3'd0);
                  end else if (rc_ff < ready_lim_ff) begin
                     rc_in = 24'(rc_ff + 24'd1);
                  end else begin
                     eng_in = E_SELFAIL; cs_in = 1'b0;
                  end
               end
               E_SELFAIL: begin
                  eng_in = E_NONE; do_cres = 1'b1; cr_r = FILL_BYTE; cr_sf = 1'b1;
               end
               E_FRAME: begin
                  out_in.mosi_valid = 1'b1; cs_in = 1'b1;
                  if (bi_ff < ((code_ff == CMD12) ? 10'd7 : 10'd6)) begin
                     out_in.mosi_byte = frame_byte(code_ff, arg_ff, crc_ff, bi_ff[2:0]);
                     bi_in = bi_n;
                  end else begin
                     rc_in = 24'd0; eng_in = E_RESP; out_in.mosi_byte = FILL_BYTE;
                  end
               end
               default: begin
                  if (m[7] && rc_ff < {16'd0, resp_lim_ff}) begin
                     rc_in = 24'(rc_ff + 24'd1);
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  end else begin
                     eng_in = E_NONE; do_cres = 1'b1; cr_r = m;
                  end
               end
            endcase
         end else begin
            case (phase_ff)
               I_WAKE: begin
                  bi_in = bi_n;
                  if (bi_n < {2'd0, wake_ff}) begin
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b0;
                  end else begin
                     tries_in = 16'd0;
                     do_start = 1'b1; sc = mk_cmd(CMD0, 32'd0, CRC_CMD0, I_CMD0);
                  end
               end
               I_R7, I_OCR: begin
                  rb_in[bi_ff[1:0]] = m;
                  bi_in = bi_n;
                  if (bi_n < 10'd4) begin
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  end else if (phase_ff == I_OCR) begin
                     dt_in = rb_in[0][6] ? CT_SDHC : CT_SD2;
                     do_fin = 1'b1;
                  end else if (rb_in[2] == 8'h01 && rb_in[3] == ARG_CMD8[7:0]) begin
                     tries_in = 16'd0;
                     do_start = 1'b1; sc = mk_cmd(CMD55, 32'd0, CRC_DUMMY, I_V2_55);
                  end else begin
                     do_fin = 1'b1;
                  end
               end
               R_TOKEN: begin
                  if (m == TOK_START) begin
                     bi_in = 10'd0; phase_in = R_DATA;
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  end else if (rc_ff < {8'd0, tok_lim_ff}) begin
                     rc_in = 24'(rc_ff + 24'd1);
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  end else begin
                     if (err_in == ST_OK) err_in = ST_TOKEN_TO;
                     if (multi_ff) begin
                        do_start = 1'b1; sc = mk_cmd(CMD12, 32'd0, CRC_DUMMY, R_STOP);
                     end else begin
                        do_fin = 1'b1;
                     end
                  end
               end
               R_DATA: begin
                  out_in.read_valid = 1'b1; out_in.read_data = m;
                  if (bi_n >= 10'(BLOCK_BYTES)) begin
                     bi_in = 10'd0; phase_in = R_CRC;
                  end else begin
                     bi_in = bi_n;
                  end
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
               end
               R_CRC: begin
                  bi_in = bi_n;
                  if (bi_n < 10'd2) begin
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  end else begin
                     bl_in = bl_n;
                     if (multi_ff && bl_n != 8'd0) begin
                        rc_in = 24'd0; phase_in = R_TOKEN;
                        out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                     end else if (multi_ff) begin
                        do_start = 1'b1; sc = mk_cmd(CMD12, 32'd0, CRC_DUMMY, R_STOP);
                     end else begin
                        do_fin = 1'b1;
                     end
                  end
               end
               W_READY: begin
                  if (m == FILL_BYTE) begin
                     bi_in = 10'd0; phase_in = W_DATA; out_in.write_request = 1'b1;
                     out_in.mosi_valid = 1'b1; cs_in = 1'b1;
                     out_in.mosi_byte = multi_ff ? TOK_MULTI : TOK_START;
                  end else if (rc_ff < ready_lim_ff) begin
                     rc_in = 24'(rc_ff + 24'd1);
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  end else begin
                     if (err_in == ST_OK) err_in = ST_BUSY_TO;
                     if (multi_ff) begin
                        rc_in = 24'd0; phase_in = W_STOPRDY;
                        out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                     end else begin
                        do_fin = 1'b1;
                     end
                  end
               end
               W_DATA: begin
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = in_ff.write_data;
                  cs_in = 1'b1;
                  if (bi_n < 10'(BLOCK_BYTES)) begin
                     out_in.write_request = 1'b1; bi_in = bi_n;
                  end else begin
                     bi_in = 10'd0; phase_in = W_CRC;
                  end
               end
               W_CRC: begin
                  bi_in = bi_n;
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  if (bi_n >= 10'd3) phase_in = W_RESP;
               end
               W_RESP: begin
                  if ((m & 8'h1F) != DRESP_OK && err_in == ST_OK) err_in = ST_WR_REJECT;
                  bl_in = bl_n;
                  if (!multi_ff) begin
                     do_fin = 1'b1;
                  end else begin
                     rc_in = 24'd0;
                     phase_in = (err_in == ST_OK && bl_n != 8'd0) ? W_READY : W_STOPRDY;
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  end
               end
               W_STOPRDY: begin
                  if (m == FILL_BYTE) begin
                     phase_in = W_STOPTOK;
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = TOK_STOP; cs_in = 1'b1;
                  end else if (rc_ff < ready_lim_ff) begin
                     rc_in = 24'(rc_ff + 24'd1);
                     out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
                  end else begin
                     if (err_in == ST_OK) err_in = ST_BUSY_TO;
                     do_fin = 1'b1;
                  end
               end
               W_STOPTOK: do_fin = 1'b1;
               default: begin
                  out_in.done_res = 1'b1;
                  if (op_ff == OP_INIT) begin
                     out_in.status = (dt_ff != CT_NONE) ? ST_OK : ST_INIT_FAIL;
                     fast_in = 1'b1;
                  end else begin
                     out_in.status = err_ff;
                  end
                  cs_in = 1'b0; phase_in = PH_IDLE;
               end
            endcase
         end
      end

      // command response handling
      if (do_cres) begin
         e_cr = cr_sf ? ST_BUSY_TO : (cr_r[7] ? ST_NO_RESP : ST_CMD_ERR);
         lr_in = cr_r;
         case (phase_ff)
            I_CMD0: begin
               if (cr_r == 8'h01) begin
                  do_start = 1'b1; sc = mk_cmd(CMD8, ARG_CMD8, CRC_CMD8, I_CMD8);
               end else if (tries_ff < {8'd0, reset_lim_ff}) begin
                  tries_in = 16'(tries_ff + 16'd1);
                  do_start = 1'b1; sc = mk_cmd(CMD0, 32'd0, CRC_CMD0, I_CMD0);
               end else begin
                  do_fin = 1'b1;
               end
            end
            I_CMD8: begin
               if (cr_r == 8'h01) begin
                  bi_in = 10'd0; phase_in = I_R7;
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
               end else begin
                  do_start = 1'b1; sc = mk_cmd(CMD55, 32'd0, CRC_DUMMY, I_V1_55);
               end
            end
            I_V2_55: begin
               do_start = 1'b1; sc = mk_cmd(CMD41, ARG_HCS, CRC_DUMMY, I_V2_41);
            end
            I_V2_41: begin
               if (cr_r == 8'd0) begin
                  do_start = 1'b1; sc = mk_cmd(CMD58, 32'd0, CRC_DUMMY, I_CMD58);
               end else if (tries_ff < init_lim_ff) begin
                  tries_in = 16'(tries_ff + 16'd1);
                  do_start = 1'b1; sc = mk_cmd(CMD55, 32'd0, CRC_DUMMY, I_V2_55);
               end else begin
                  do_fin = 1'b1;
               end
            end
            I_CMD58: begin
               if (cr_r == 8'd0) begin
                  bi_in = 10'd0; phase_in = I_OCR;
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
               end else begin
                  do_fin = 1'b1;
               end
            end
            I_V1_55: begin
               do_start = 1'b1; sc = mk_cmd(CMD41, 32'd0, CRC_DUMMY, I_V1_41);
            end
            I_V1_41: begin
               tries_in = 16'd0; do_start = 1'b1;
               if (cr_r <= 8'd1) begin
                  dt_in = CT_SD1; sc = mk_cmd(CMD55, 32'd0, CRC_DUMMY, I_V1L_55);
               end else begin
                  dt_in = CT_MMC; sc = mk_cmd(CMD1, 32'd0, CRC_DUMMY, I_MMC);
               end
            end
            I_V1L_55: begin
               do_start = 1'b1; sc = mk_cmd(CMD41, 32'd0, CRC_DUMMY, I_V1L_41);
            end
            I_V1L_41, I_MMC: begin
               if (cr_r == 8'd0) begin
                  do_start = 1'b1;
                  sc = mk_cmd(CMD16, 32'(BLOCK_BYTES), CRC_DUMMY, I_CMD16);
               end else if (tries_ff < init_lim_ff) begin
                  tries_in = 16'(tries_ff + 16'd1); do_start = 1'b1;
                  if (phase_ff == I_MMC)
                     sc = mk_cmd(CMD1, 32'd0, CRC_DUMMY, I_MMC);
                  else
                     sc = mk_cmd(CMD55, 32'd0, CRC_DUMMY, I_V1L_55);
               end else begin
                  dt_in = CT_NONE; do_fin = 1'b1;
               end
            end
            I_CMD16: begin
               if (cr_r != 8'd0) dt_in = CT_NONE;
               do_fin = 1'b1;
            end
            R_CMD: begin
               if (cr_r == 8'd0) begin
                  rc_in = 24'd0; phase_in = R_TOKEN;
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
               end else begin
                  if (err_in == ST_OK) err_in = e_cr;
                  if (multi_ff) begin
                     do_start = 1'b1; sc = mk_cmd(CMD12, 32'd0, CRC_DUMMY, R_STOP);
                  end else begin
                     do_fin = 1'b1;
                  end
               end
            end
            W_55: begin
               do_start = 1'b1; sc = mk_cmd(CMD23, {24'd0, bl_ff}, CRC_DUMMY, W_23);
            end
            W_23: begin
               do_start = 1'b1; sc = mk_cmd(CMD25, ba_ff, CRC_DUMMY, W_CMD);
            end
            W_CMD: begin
               if (cr_r == 8'd0) begin
                  rc_in = 24'd0; phase_in = W_READY;
                  out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b1;
               end else begin
                  if (err_in == ST_OK) err_in = e_cr;
                  do_fin = 1'b1;
               end
            end
            default: do_fin = 1'b1;
         endcase
      end

      if (do_start) begin
         code_in = sc.code; arg_in = sc.arg; crc_in = sc.crc;
         phase_in = sc.next; eng_in = E_DESEL;
         out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b0;
      end
      if (do_fin) begin
         eng_in = E_NONE; phase_in = PH_FIN;
         out_in.mosi_valid = 1'b1; out_in.mosi_byte = FILL_BYTE; cs_in = 1'b0;
      end

      out_in.cs_active     = cs_in;
      out_in.fast_clock    = fast_in;
      out_in.response_code = lr_in;
      out_in.card_type     = dt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_lim_ff <= 8'd20;
         init_lim_ff  <= 16'd65534;
         resp_lim_ff  <= 8'd31;
         ready_lim_ff <= 24'd16777214;
         tok_lim_ff   <= 16'd4095;
         wake_ff      <= 8'd10;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_RESET_RETRY: reset_lim_ff <= pwdata[7:0];
            REG_INIT_RETRY:  init_lim_ff  <= pwdata[15:0];
            REG_RESP_POLL:   resp_lim_ff  <= pwdata[7:0];
            REG_READY_WAIT:  ready_lim_ff <= pwdata[23:0];
            REG_TOKEN_WAIT:  tok_lim_ff   <= pwdata[15:0];
            REG_WAKEUP:      wake_ff      <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_data;
      if (advance) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_ready) in_v_ff <= req_valid;
         if (advance) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; eng_ff <= E_NONE; bi_ff <= 10'd0; rc_ff <= 24'd0;
         dt_ff <= CT_NONE; ba_ff <= 32'd0; bl_ff <= 8'd0; lr_ff <= 8'd0;
         rb_ff <= '{default: 8'd0};
         op_ff <= OP_INIT; tries_ff <= 16'd0; code_ff <= CMD0; arg_ff <= 32'd0;
         crc_ff <= 8'd0; err_ff <= ST_OK; multi_ff <= 1'b0; cs_ff <= 1'b0;
         fast_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in; eng_ff <= eng_in; bi_ff <= bi_in; rc_ff <= rc_in;
         dt_ff <= dt_in; ba_ff <= ba_in; bl_ff <= bl_in; lr_ff <= lr_in;
         rb_ff <= rb_in;
         op_ff <= op_in; tries_ff <= tries_in; code_ff <= code_in; arg_ff <= arg_in;
         crc_ff <= crc_in; err_ff <= err_in; multi_ff <= multi_in; cs_ff <= cs_in;
         fast_ff <= fast_in;
      end
   end

endmodule
